// File: rtl/core/sorted_set_insert_delete_search_unit_assert.svh
// Assertion shorthands used by the checker of this block.
// Each expects clk and rst_n in scope.
`ifndef SORTED_SET_INSERT_DELETE_SEARCH_UNIT_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define SSET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sset_pkg.sv
`default_nettype none

package sset_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 16;

  // held count must represent CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // port field widths
  localparam int CMD_W     = 2;
  localparam int KEY_W     = 16;
  localparam int TAG_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEL_MISS  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      count_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // run the operation and fill the result register
  } sset_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/sset_cell.sv
`default_nettype none

// One slot of the sorted row: compares against the broadcast key and
// shifts toward higher slots on insert, lower slots on delete.
module sset_cell (
  input  wire logic            clk,
  input  wire logic            ins_en,
  input  wire logic            del_en,
  input  wire sset_pkg::value_t key,
  input  wire logic            in_use,
  input  wire logic            prev_lt,
  input  wire sset_pkg::value_t prev_entry,
  input  wire sset_pkg::value_t next_entry,
  output sset_pkg::value_t     entry,
  output logic                 lt,
  output logic                 eq
);

  sset_pkg::value_t entry_r;
  sset_pkg::value_t entry_nxt;

  assign lt    = in_use && (entry_r < key);
  assign eq    = in_use && (entry_r == key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ins_en && !lt) begin
      // first slot at or above the key takes the key, the rest move up
      entry_nxt = prev_lt ? key : prev_entry;
    end else if (del_en && !lt) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/sset_ctrl.sv
`default_nettype none

module sset_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output sset_pkg::sset_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the item until the result register can take the answer
        if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sset_datapath.sv
`default_nettype none

module sset_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sset_pkg::sset_cmd_t                 cmd,
  input  wire logic [sset_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic [sset_pkg::KEY_W-1:0]          in_key_value,
  input  wire logic [sset_pkg::TAG_W-1:0]          in_task_tag,
  output logic      [sset_pkg::TAG_W-1:0]          out_result_tag,
  output logic      [sset_pkg::STATUS_W-1:0]       out_status,
  output logic      [sset_pkg::OUT_CNT_W-1:0]      out_entry_count
);

  localparam int CAP = sset_pkg::CAPACITY;

  logic [sset_pkg::CMD_W-1:0]    op_r;
  sset_pkg::value_t              key_r;
  logic [sset_pkg::TAG_W-1:0]    tag_r;
  sset_pkg::count_t              count_r;
  sset_pkg::count_t              count_nxt;

  logic [sset_pkg::TAG_W-1:0]    res_tag_r;
  logic [sset_pkg::STATUS_W-1:0] res_status_r;
  logic [sset_pkg::STATUS_W-1:0] res_status_nxt;
  logic [sset_pkg::OUT_CNT_W-1:0] res_count_r;

  logic [CAP-1:0]   lt_vec;
  logic [CAP-1:0]   eq_vec;
  sset_pkg::value_t ent [CAP];

  logic hit;
  logic full;
  logic ins_en;
  logic del_en;

  assign hit  = |eq_vec;
  assign full = (count_r == sset_pkg::CNT_W'(CAP));

  assign ins_en = cmd.exec && (op_r == sset_pkg::CMD_INSERT) && !hit && !full;
  assign del_en = cmd.exec && (op_r == sset_pkg::CMD_DELETE) && hit;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic             in_use;
    logic             prev_lt;
    sset_pkg::value_t prev_entry;
    sset_pkg::value_t next_entry;

    assign in_use = (sset_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_entry = key_r;
    end else begin : g_mid
      assign prev_lt    = lt_vec[i-1];
      assign prev_entry = ent[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign next_entry = ent[i];
    end else begin : g_body
      assign next_entry = ent[i+1];
    end

    sset_cell u_cell (
      .clk        (clk),
      .ins_en     (ins_en),
      .del_en     (del_en),
      .key        (key_r),
      .in_use     (in_use),
      .prev_lt    (prev_lt),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (ent[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_en) begin
      count_nxt = count_r + sset_pkg::CNT_W'(1);
    end else if (del_en) begin
      count_nxt = count_r - sset_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    case (op_r)
      sset_pkg::CMD_INSERT: begin
        // a present value answers duplicate even when full
        if (hit) begin
          res_status_nxt = sset_pkg::ST_DUPLICATE;
        end else if (full) begin
          res_status_nxt = sset_pkg::ST_FULL;
        end else begin
          res_status_nxt = sset_pkg::ST_INSERTED;
        end
      end
      sset_pkg::CMD_DELETE: begin
        res_status_nxt = hit ? sset_pkg::ST_DELETED : sset_pkg::ST_DEL_MISS;
      end
      default: begin
        // unused code behaves as search
        res_status_nxt = hit ? sset_pkg::ST_FOUND : sset_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_cmd;
      key_r <= sset_pkg::VALUE_BITS'(in_key_value);
      tag_r <= in_task_tag;
    end
    if (cmd.exec) begin
      res_tag_r    <= tag_r;
      res_status_r <= res_status_nxt;
      res_count_r  <= sset_pkg::OUT_CNT_W'(count_nxt);
    end
  end

  assign out_result_tag  = res_tag_r;
  assign out_status      = res_status_r;
  assign out_entry_count = res_count_r;

endmodule

`default_nettype wire

// File: rtl/core/sorted_set_insert_delete_search_unit.sv
// Sorted set store: keeps up to 64 distinct 16-bit values in ascending order.
// Input channel (in_valid / in_stall): one task per transfer, in_cmd selects
// insert (0), delete (1) or search (2; code 3 also searches), with
// in_key_value and in_task_tag. Result channel (out_valid / out_stall): one
// result per task, in order, with out_result_tag, out_status and
// out_entry_count (values held after the operation).
// Timing: a task is taken into the load registers, then executed once the
// result register is free; all slots compare the key in parallel and shift
// in the same cycle, and the result is registered at that same edge, where
// out_valid rises. A new task is taken only after the previous one has
// executed, set by the load/execute sequence of the controller around the
// single result register.
// While a result waits under out_stall, one further task is still taken and
// held; it executes only once the result register frees, and in_stall stays
// high meanwhile.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// result; no clearing pass is needed, the held count alone marks live slots.
`default_nettype none

module sorted_set_insert_delete_search_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [sset_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [sset_pkg::KEY_W-1:0]     in_key_value,
  input  wire logic [sset_pkg::TAG_W-1:0]     in_task_tag,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [sset_pkg::TAG_W-1:0]     out_result_tag,
  output logic      [sset_pkg::STATUS_W-1:0]  out_status,
  output logic      [sset_pkg::OUT_CNT_W-1:0] out_entry_count
);

  sset_pkg::sset_cmd_t cmd;

  sset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sset_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_cmd          (in_cmd),
    .in_key_value    (in_key_value),
    .in_task_tag     (in_task_tag),
    .out_result_tag  (out_result_tag),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

// File: rtl/core/sset_checker.sv
`default_nettype none

`include "sorted_set_insert_delete_search_unit_assert.svh"

module sset_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [sset_pkg::TAG_W-1:0]     out_result_tag,
  input wire logic [sset_pkg::STATUS_W-1:0]  out_status,
  input wire logic [sset_pkg::OUT_CNT_W-1:0] out_entry_count
);

  localparam int RES_W = sset_pkg::TAG_W + sset_pkg::STATUS_W + sset_pkg::OUT_CNT_W;
  localparam logic [sset_pkg::OUT_CNT_W-1:0] FULL_CNT =
    sset_pkg::OUT_CNT_W'(sset_pkg::CAPACITY);

  logic             in_take;
  logic             out_hold;
  logic             ins_shown;
  logic             full_shown;
  logic [RES_W-1:0] res_word;

  assign in_take    = in_valid && !in_stall;
  assign out_hold   = out_valid && out_stall;
  assign ins_shown  = out_valid && (out_status == sset_pkg::ST_INSERTED);
  assign full_shown = out_valid && (out_status == sset_pkg::ST_FULL);
  assign res_word   = {out_result_tag, out_status, out_entry_count};

  // stalled result holds
  `SSET_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(res_word), "stalled result moved")

  // a taken task is executed before the next one is taken
  `SSET_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "task taken while busy")

  `SSET_ASSERT_NOW(a_insert_count, ins_shown, out_entry_count != '0, "insert left store empty")

  `SSET_ASSERT_NOW(a_full_count, full_shown, out_entry_count == FULL_CNT, "full below capacity")

endmodule

bind sorted_set_insert_delete_search_unit sset_checker u_sset_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_tag  (out_result_tag),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

`default_nettype wire

// File: tb/sorted_set_insert_delete_search_unit_tb.sv
`timescale 1ns / 100ps

module sorted_set_insert_delete_search_unit_tb;

  // code 3 is unused and behaves as a search
  localparam logic [sset_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int POOL_SIZE = 80;

  typedef struct {
    logic [sset_pkg::TAG_W-1:0]     tag;
    logic [sset_pkg::STATUS_W-1:0]  status;
    logic [sset_pkg::OUT_CNT_W-1:0] count;
  } answer_t;

  // Mirror of the sorted store plus the answers still owed by the block.
  class set_tracker;
    sset_pkg::value_t held[$];
    answer_t          owed[$];
    int unsigned      errors;
    int unsigned      answered;
    int unsigned      peak;
    int unsigned      status_seen[7];

    function void note_task(logic [sset_pkg::CMD_W-1:0] cmd,
                            logic [sset_pkg::KEY_W-1:0] key,
                            logic [sset_pkg::TAG_W-1:0] tag);
      sset_pkg::value_t v;
      int               pos;
      bit               hit;
      answer_t          a;
      v = key[sset_pkg::VALUE_BITS-1:0];
      pos = 0;
      while (pos < held.size() && held[pos] < v) pos++;
      hit = (pos < held.size()) && (held[pos] == v);
      case (cmd)
        sset_pkg::CMD_INSERT: begin
          if (hit) a.status = sset_pkg::ST_DUPLICATE;
          else if (held.size() >= sset_pkg::CAPACITY) a.status = sset_pkg::ST_FULL;
          else begin
            held.insert(pos, v);
            a.status = sset_pkg::ST_INSERTED;
          end
        end
        sset_pkg::CMD_DELETE: begin
          if (hit) begin
            held.delete(pos);
            a.status = sset_pkg::ST_DELETED;
          end else begin
            a.status = sset_pkg::ST_DEL_MISS;
          end
        end
        default: a.status = hit ? sset_pkg::ST_FOUND : sset_pkg::ST_NOT_FOUND;
      endcase
      a.tag = tag;
      a.count = sset_pkg::OUT_CNT_W'(held.size());
      if (held.size() > peak) peak = held.size();
      owed.push_back(a);
    endfunction

    function void check_answer(logic [sset_pkg::TAG_W-1:0] tag,
                               logic [sset_pkg::STATUS_W-1:0] status,
                               logic [sset_pkg::OUT_CNT_W-1:0] count);
      answer_t a;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tag %h status %0d count %0d",
                 $time, tag, status, count);
        errors++;
        return;
      end
      a = owed.pop_front();
      answered++;
      if (status < 7) status_seen[status]++;
      if (tag !== a.tag) begin
        $display("%0t: result_tag expected %h got %h", $time, a.tag, tag);
        errors++;
      end
      if (status !== a.status) begin
        $display("%0t: status (tag %h) expected %0d got %0d",
                 $time, a.tag, a.status, status);
        errors++;
      end
      if (count !== a.count) begin
        $display("%0t: entry_count (tag %h) expected %0d got %0d",
                 $time, a.tag, a.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [sset_pkg::CMD_W-1:0]     in_cmd = sset_pkg::CMD_SEARCH;
  logic [sset_pkg::KEY_W-1:0]     in_key_value = '0;
  logic [sset_pkg::TAG_W-1:0]     in_task_tag = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [sset_pkg::TAG_W-1:0]     out_result_tag;
  logic [sset_pkg::STATUS_W-1:0]  out_status;
  logic [sset_pkg::OUT_CNT_W-1:0] out_entry_count;

  set_tracker                 tracker = new();
  int unsigned                gap_pct = 0;
  int unsigned                hold_pct = 0;
  logic [sset_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  sorted_set_insert_delete_search_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_key_value   (in_key_value),
    .in_task_tag    (in_task_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_tag (out_result_tag),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < hold_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_task(in_cmd, in_key_value, in_task_tag);
      if (out_valid && !out_stall)
        tracker.check_answer(out_result_tag, out_status, out_entry_count);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high.
  task automatic send_task(logic [sset_pkg::CMD_W-1:0] cmd,
                           logic [sset_pkg::KEY_W-1:0] key,
                           logic [sset_pkg::TAG_W-1:0] tag);
    while ($urandom_range(99) < gap_pct) begin
      in_valid     <= 1'b0;
      in_cmd       <= sset_pkg::CMD_W'($urandom);
      in_key_value <= sset_pkg::KEY_W'($urandom);
      in_task_tag  <= sset_pkg::TAG_W'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_key_value <= key;
    in_task_tag  <= tag;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Sender holds off until every owed answer has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(int n, int ins_pct, int del_pct, int pool_pct,
                           int gap, int hold);
    logic [sset_pkg::CMD_W-1:0] cmd;
    logic [sset_pkg::KEY_W-1:0] key;
    int                         r;
    gap_pct  = gap;
    hold_pct = hold;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < ins_pct) cmd = sset_pkg::CMD_INSERT;
      else if (r < ins_pct + del_pct) cmd = sset_pkg::CMD_DELETE;
      else if (r < 95) cmd = sset_pkg::CMD_SEARCH;
      else cmd = CMD_UNUSED;
      if ($urandom_range(99) < pool_pct) key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else key = sset_pkg::KEY_W'($urandom);
      send_task(cmd, key, sset_pkg::TAG_W'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h0001;
    key_pool[3] = 16'hFFFE;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = sset_pkg::KEY_W'($urandom);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty store, extremes, duplicates, unused code
    send_task(sset_pkg::CMD_SEARCH, 16'h0000, 16'h0000);
    send_task(sset_pkg::CMD_DELETE, 16'h0000, 16'hFFFF);
    send_task(CMD_UNUSED, 16'hFFFF, 16'h5555);
    send_task(sset_pkg::CMD_INSERT, 16'hFFFF, 16'hAAAA);
    send_task(sset_pkg::CMD_INSERT, 16'h0000, 16'h0001);
    send_task(sset_pkg::CMD_INSERT, 16'h8000, 16'h0002);
    send_task(sset_pkg::CMD_INSERT, 16'h0000, 16'h0003);
    send_task(sset_pkg::CMD_INSERT, 16'h7FFF, 16'h0004);
    send_task(sset_pkg::CMD_SEARCH, 16'hFFFF, 16'h0005);
    send_task(CMD_UNUSED, 16'h8000, 16'h0006);
    send_task(sset_pkg::CMD_SEARCH, 16'h8001, 16'h0007);
    send_task(sset_pkg::CMD_DELETE, 16'h8000, 16'h0008);
    send_task(sset_pkg::CMD_DELETE, 16'h8000, 16'h0009);
    send_task(sset_pkg::CMD_SEARCH, 16'h8000, 16'h000A);
    send_task(sset_pkg::CMD_DELETE, 16'h0000, 16'h000B);
    send_task(sset_pkg::CMD_DELETE, 16'hFFFF, 16'h000C);
    send_task(sset_pkg::CMD_DELETE, 16'h7FFF, 16'h000D);
    send_task(sset_pkg::CMD_SEARCH, 16'h7FFF, 16'h000E);
    wait_drained();

    // fill to capacity, first with back-to-back transfers, then with gaps
    run_phase(225, 75, 10, 85, 0, 0);
    run_phase(225, 40, 30, 85, 74, 0);
    // drain while the result side stalls
    run_phase(225, 10, 70, 85, 0, 74);
    run_phase(225, 45, 35, 70, 6, 6);

    hold_pct = 0;
    repeat (10) @(negedge clk);
    $display("covered %0d tasks, store peaked at %0d of %0d values",
             tracker.answered, tracker.peak, sset_pkg::CAPACITY);
    $display("outcomes ins %0d dup %0d del %0d miss %0d found %0d absent %0d full %0d",
             tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
             tracker.status_seen[3], tracker.status_seen[4], tracker.status_seen[5],
             tracker.status_seen[6]);
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d answers owed", tracker.owed.size());
    $display("FAIL");
    $finish;
  end

endmodule
